// ----- rtl/harris_corner_response_assert.svh -----
// Assertion macros shared by the Harris corner response RTL.
`ifndef HARRIS_CORNER_RESPONSE_ASSERT_SVH
`define HARRIS_CORNER_RESPONSE_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define HCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define HCR_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hcr_pkg.sv -----
// Shared types and constants of the Harris corner response block.
package hcr_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_AW-1:0] REG_HARRIS_K     = 2'd2;

    localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [10:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [15:0] RST_HARRIS_K     = 16'd2621;

    localparam int RESP_W = 40;
    localparam int FMAX_W = 39;
    localparam int POS_W  = 10;

    // Gradient products of one position, as held in the product line.
    typedef struct packed {
        logic signed [17:0] xx;
        logic signed [17:0] yy;
        logic signed [17:0] xy;
    } t_prod;

endpackage

// ----- rtl/hcr_line_store.sv -----
// Line stores for the two previous pixel rows and the row of gradient products.
module hcr_line_store #(
    parameter int MAX_WIDTH = hcr_pkg::DEF_MAX_WIDTH,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic           i_clk,
    input  logic           i_rd_en,
    input  logic [AW-1:0]  i_rd_addr,
    input  logic [AW-1:0]  i_rd_nxt_addr,
    input  logic           i_wr_en,
    input  logic [AW-1:0]  i_wr_addr,
    input  logic [7:0]     i_wr_pix_a,
    input  logic [7:0]     i_wr_pix_b,
    input  hcr_pkg::t_prod i_wr_prod,
    output logic [7:0]     o_rd_pix_a,
    output logic [7:0]     o_rd_pix_b,
    output logic [7:0]     o_rd_nxt_pix_a,
    output hcr_pkg::t_prod o_rd_prod
);

    // Both pixel rows share one entry: row above in the upper byte.
    logic [15:0]    r_pix_mem  [MAX_WIDTH];
    hcr_pkg::t_prod r_prod_mem [MAX_WIDTH];

    logic [15:0]    r_pix_q;
    logic [15:0]    r_nxt_q;
    hcr_pkg::t_prod r_prod_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_pix_mem[i_wr_addr]  <= {i_wr_pix_a, i_wr_pix_b};
            r_prod_mem[i_wr_addr] <= i_wr_prod;
        end
        if (i_rd_en) begin
            r_pix_q  <= r_pix_mem[i_rd_addr];
            r_nxt_q  <= r_pix_mem[i_rd_nxt_addr];
            r_prod_q <= r_prod_mem[i_rd_addr];
        end
    end

    assign o_rd_pix_a     = r_pix_q[15:8];
    assign o_rd_pix_b     = r_pix_q[7:0];
    assign o_rd_nxt_pix_a = r_nxt_q[15:8];
    assign o_rd_prod      = r_prod_q;

endmodule

// ----- rtl/harris_corner_response.sv -----
// Top level of the Harris corner response block.
//
// Pixels enter in raster order on the pixel channel (valid and ready); an item
// is taken at a clock edge where i_pixel_valid and o_pixel_ready are both high.
// Each interior position yields one result item on the result channel, which
// carries the response, its row and column, the running frame maximum and a
// flag on the last position of the frame. The result of position (i, j) is
// produced when pixel (i+1, j) arrives.
// A pixel that produces a result passes through a read of the line stores, a
// step for gradients and box sums, two multiplier stages for the determinant
// and the trace penalty, and one stage that forms the response and loads the
// output register; a pixel that produces no result ends after the gradient
// step. The block takes no new pixel until the last one has left these steps.
// A finished result waits in an output register; the block keeps taking pixels
// while it waits and only stops in the final stage if a second result is ready
// before the first was taken.
// Configuration writes go through a plain write port and take effect at once;
// the user must make them only while the block is idle; the block does not check.
// Reset is synchronous and active low; it restores the default frame size and k, and restarts at pixel (0, 0).
module harris_corner_response #(
    parameter int MAX_WIDTH  = hcr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hcr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hcr_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [hcr_pkg::CFG_DW-1:0]     i_cfg_wdata,
    input  logic                           i_pixel_valid,
    output logic                           o_pixel_ready,
    input  logic [7:0]                     i_pixel,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output logic signed [hcr_pkg::RESP_W-1:0] o_response,
    output logic [hcr_pkg::POS_W-1:0]      o_row,
    output logic [hcr_pkg::POS_W-1:0]      o_col,
    output logic [hcr_pkg::FMAX_W-1:0]     o_frame_max,
    output logic                           o_is_last
);

    `include "harris_corner_response_assert.svh"

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int SW_W = CW + 1;
    localparam int SW_H = RW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_PEN  = 3'd3;
    localparam logic [2:0] S_RES  = 3'd4;

    // Configuration registers.
    logic [10:0] r_cfg_width;
    logic [10:0] r_cfg_height;
    logic [15:0] r_cfg_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= hcr_pkg::RST_FRAME_WIDTH;
            r_cfg_height <= hcr_pkg::RST_FRAME_HEIGHT;
            r_cfg_k      <= hcr_pkg::RST_HARRIS_K;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                hcr_pkg::REG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_wdata[10:0];
                hcr_pkg::REG_FRAME_HEIGHT: r_cfg_height <= i_cfg_wdata[10:0];
                hcr_pkg::REG_HARRIS_K:     r_cfg_k      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Frame size in use, clamped to the supported range.
    logic [SW_W-1:0] w_eff;
    logic [SW_H-1:0] h_eff;

    always_comb begin
        if (r_cfg_width < 11'd3) begin
            w_eff = SW_W'(3);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            w_eff = SW_W'(MAX_WIDTH);
        end else begin
            w_eff = SW_W'(r_cfg_width);
        end
        if (r_cfg_height < 11'd3) begin
            h_eff = SW_H'(3);
        end else if (32'(r_cfg_height) > MAX_HEIGHT) begin
            h_eff = SW_H'(MAX_HEIGHT);
        end else begin
            h_eff = SW_H'(r_cfg_height);
        end
    end

    // Control and datapath registers.
    logic [2:0]            r_state;
    logic [CW-1:0]         r_col;
    logic [RW-1:0]         r_row;
    logic [CW-1:0]         r_c;
    logic [RW-1:0]         r_r;
    logic [7:0]            r_pix;
    logic                  r_emit;
    logic                  r_last;
    logic                  r_right_ok;
    logic [7:0]            r_above_left;
    hcr_pkg::t_prod        r_left;
    hcr_pkg::t_prod        r_diag;
    logic signed [19:0]    r_sxx;
    logic signed [19:0]    r_syy;
    logic signed [19:0]    r_sxy;
    logic signed [39:0]    r_det_a;
    logic signed [39:0]    r_det_b;
    logic [37:0]           r_tr2;
    logic signed [39:0]    r_det;
    logic [37:0]           r_pen;
    logic [hcr_pkg::FMAX_W-1:0] r_max;
    logic                  r_out_valid;
    logic signed [hcr_pkg::RESP_W-1:0] r_out_resp;
    logic [hcr_pkg::POS_W-1:0] r_out_row;
    logic [hcr_pkg::POS_W-1:0] r_out_col;
    logic [hcr_pkg::FMAX_W-1:0] r_out_max;
    logic                  r_out_last;

    // Position of the arriving pixel, after wrapping for a shrunken frame.
    logic [SW_W-1:0] col_ext;
    logic [SW_H-1:0] row_nx;
    logic [CW-1:0]   cur_c;
    logic [RW-1:0]   cur_r;
    logic [SW_W-1:0] cur_c_ext;
    logic [SW_H-1:0] cur_r_ext;
    logic [SW_W-1:0] c_p1;
    logic [SW_W-1:0] c_p2;
    logic [SW_H-1:0] r_p1;
    logic            acc;

    always_comb begin
        col_ext = {1'b0, r_col};
        row_nx  = {1'b0, r_row};
        cur_c   = r_col;
        if (col_ext >= w_eff) begin
            cur_c  = '0;
            row_nx = row_nx + 1'b1;
        end
        if (row_nx >= h_eff) begin
            row_nx = '0;
        end
        cur_r     = row_nx[RW-1:0];
        cur_c_ext = {1'b0, cur_c};
        cur_r_ext = {1'b0, cur_r};
        c_p1      = cur_c_ext + 1'b1;
        c_p2      = cur_c_ext + SW_W'(2);
        r_p1      = cur_r_ext + 1'b1;
    end

    assign acc           = i_pixel_valid && (r_state == S_IDLE);
    assign o_pixel_ready = (r_state == S_IDLE);

    // Line stores.
    logic [7:0]     rd_a;
    logic [7:0]     rd_b;
    logic [7:0]     rd_nxt_a;
    hcr_pkg::t_prod rd_prod;
    hcr_pkg::t_prod p;
    logic           wr_en;

    hcr_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (CW)
    ) u_store (
        .i_clk          (i_clk),
        .i_rd_en        (acc),
        .i_rd_addr      (cur_c),
        .i_rd_nxt_addr  (c_p1[CW-1:0]),
        .i_wr_en        (wr_en),
        .i_wr_addr      (r_c),
        .i_wr_pix_a     (r_pix),
        .i_wr_pix_b     (rd_a),
        .i_wr_prod      (p),
        .o_rd_pix_a     (rd_a),
        .o_rd_pix_b     (rd_b),
        .o_rd_nxt_pix_a (rd_nxt_a),
        .o_rd_prod      (rd_prod)
    );

    assign wr_en = (r_state == S_CALC);

    // Gradients, products and 2x2 box sums.
    logic signed [9:0]  dx;
    logic signed [9:0]  dy;
    logic [7:0]         right_pix;
    logic signed [19:0] n_sxx;
    logic signed [19:0] n_syy;
    logic signed [19:0] n_sxy;

    always_comb begin
        right_pix = r_right_ok ? rd_nxt_a : 8'd0;
        dx = $signed({2'b00, right_pix}) - $signed({2'b00, r_above_left});
        dy = $signed({2'b00, r_pix}) - $signed({2'b00, rd_b});
        p  = '0;
        if (r_emit) begin
            p.xx = 18'(dx * dx);
            p.yy = 18'(dy * dy);
            p.xy = 18'(dx * dy);
        end
        n_sxx = 20'(p.xx) + 20'(r_left.xx) + 20'(rd_prod.xx) + 20'(r_diag.xx);
        n_syy = 20'(p.yy) + 20'(r_left.yy) + 20'(rd_prod.yy) + 20'(r_diag.yy);
        n_sxy = 20'(p.xy) + 20'(r_left.xy) + 20'(rd_prod.xy) + 20'(r_diag.xy);
    end

    // Trace, penalty and response.
    logic [18:0]        tr;
    logic [53:0]        pen_full;
    logic signed [40:0] resp;
    logic signed [40:0] max_ext;
    logic [hcr_pkg::FMAX_W-1:0] n_max;
    logic [RW-1:0]      row_m1;
    logic               out_free;

    always_comb begin
        tr       = r_sxx[18:0] + r_syy[18:0];
        pen_full = 54'(r_tr2) * 54'(r_cfg_k);
        resp     = $signed({r_det[39], r_det}) - $signed({3'b000, r_pen});
        max_ext  = $signed({2'b00, r_max});
        n_max    = (resp > max_ext) ? resp[hcr_pkg::FMAX_W-1:0] : r_max;
        row_m1   = r_r - 1'b1;
        out_free = !r_out_valid || i_res_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_col        <= '0;
            r_row        <= '0;
            r_max        <= '0;
            r_out_valid  <= 1'b0;
            r_left       <= '0;
            r_diag       <= '0;
            r_above_left <= '0;
        end else begin
            if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_state <= S_CALC;
                        if (cur_r == '0 && cur_c == '0) begin
                            r_max <= '0;
                        end
                        if (c_p1 >= w_eff) begin
                            r_col <= '0;
                            r_row <= (r_p1 >= h_eff) ? '0 : r_p1[RW-1:0];
                        end else begin
                            r_col <= c_p1[CW-1:0];
                            r_row <= cur_r;
                        end
                    end
                end
                S_CALC: begin
                    r_left       <= p;
                    r_diag       <= rd_prod;
                    r_above_left <= rd_a;
                    r_state      <= r_emit ? S_MUL : S_IDLE;
                end
                S_MUL: begin
                    r_state <= S_PEN;
                end
                S_PEN: begin
                    r_state <= S_RES;
                end
                S_RES: begin
                    if (out_free) begin
                        r_max       <= n_max;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_pix      <= i_pixel;
            r_c        <= cur_c;
            r_r        <= cur_r;
            r_emit     <= (cur_r_ext >= SW_H'(2)) && (cur_c != '0) && (c_p2 <= w_eff);
            r_last     <= (r_p1 == h_eff) && (c_p2 == w_eff);
            r_right_ok <= (c_p1 < w_eff);
        end
        if (r_state == S_CALC) begin
            r_sxx <= n_sxx;
            r_syy <= n_syy;
            r_sxy <= n_sxy;
        end
        if (r_state == S_MUL) begin
            r_det_a <= 40'(r_sxx) * 40'(r_syy);
            r_det_b <= 40'(r_sxy) * 40'(r_sxy);
            r_tr2   <= 38'(tr) * 38'(tr);
        end
        if (r_state == S_PEN) begin
            r_pen <= pen_full[53:16];
            r_det <= r_det_a - r_det_b;
        end
        if (r_state == S_RES && out_free) begin
            r_out_resp <= resp[hcr_pkg::RESP_W-1:0];
            r_out_row  <= hcr_pkg::POS_W'(row_m1);
            r_out_col  <= hcr_pkg::POS_W'(r_c);
            r_out_max  <= n_max;
            r_out_last <= r_last;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_response  = r_out_resp;
    assign o_row       = r_out_row;
    assign o_col       = r_out_col;
    assign o_frame_max = r_out_max;
    assign o_is_last   = r_out_last;

    // The frame maximum carried with a result never lies below its response.
    logic signed [40:0] a_fmax_ext;
    logic signed [40:0] a_resp_ext;
    assign a_fmax_ext = $signed({2'b00, o_frame_max});
    assign a_resp_ext = $signed({o_response[hcr_pkg::RESP_W-1], o_response});

    `HCR_ASSERT(a_max_covers_resp, !o_res_valid || (a_fmax_ext >= a_resp_ext), "frame max below response")
    `HCR_ASSERT_NEXT(a_accept_reads, acc, r_state == S_CALC, "accepted pixel did not reach the calc step")
    `HCR_ASSERT_NEXT(a_result_waits, (r_state == S_RES) && r_out_valid && !i_res_ready, r_state == S_RES, "result left while output was full")

endmodule
